[hdl/tra_pkg.sv]
// tra_pkg: shared constants, codes, types and helpers for the tensor roll address generator
// used by tra_ctrl, tra_dp and tensor_roll_address_generator_unit; no dependencies
package tra_pkg;

  localparam int MAX_RANK   = 4;
  localparam int DIM_BITS   = 16;
  localparam int ADDR_BITS  = 32;
  localparam int RANK_BITS  = 3;
  localparam int DIM_IDX_BITS = $clog2(MAX_RANK);

  localparam int SHIFT_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int AXIS_BITS  = 3;
  localparam int SUM_BITS   = SHIFT_BITS + 2;
  localparam int ABS_BITS   = SHIFT_BITS + 1;
  localparam int STEP_BITS  = $clog2(ABS_BITS);
  localparam int PROD_BITS  = ADDR_BITS + DIM_BITS + 1;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam int S_TDATA_BITS = 72;
  localparam int M_TDATA_BITS = 64;
  localparam int REQ_BITS     = 2;

  localparam logic [REQ_BITS-1:0] REQ_START = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_SHIFT = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_DATA  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_RANK  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE3 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_MUL,
    ST_STRIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                    clear;
    logic                    shift_load;
    logic                    div_step;
    logic                    shift_store;
    logic                    elem_load;
    logic                    mul_acc;
    logic                    mul_stride;
    logic                    out_load;
    logic [DIM_IDX_BITS-1:0] dim;
  } cmd_t;

  typedef struct packed {
    logic                 axis_ok;
    logic                 out_free;
    logic [RANK_BITS-1:0] eff_rank;
  } status_t;

  function automatic logic [DIM_BITS-1:0] eff_size(input logic [DIM_BITS-1:0] s);
    return (s == '0) ? DIM_BITS'(1) : s;
  endfunction

  function automatic logic [RANK_BITS-1:0] eff_rank(input logic [RANK_BITS-1:0] r);
    logic [RANK_BITS-1:0] res;
    res = r;
    if (r == '0) res = RANK_BITS'(1);
    if (r > RANK_BITS'(MAX_RANK)) res = RANK_BITS'(MAX_RANK);
    return res;
  endfunction

endpackage

[hdl/tra_ctrl.sv]
// tra_ctrl: sequencer for start, axis/shift and element beats
// depends on tra_pkg; drives command struct for tra_dp and reads its status
module tra_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic [tra_pkg::REQ_BITS-1:0]  req_type,
  output logic                          s_tready,
  input  tra_pkg::status_t              status,
  output tra_pkg::cmd_t                 cmd
);

  tra_pkg::state_t                       state, state_next;
  logic [tra_pkg::STEP_BITS-1:0]         step, step_next;
  logic [tra_pkg::DIM_IDX_BITS-1:0]      dim, dim_next;
  logic                                  accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tra_pkg::ST_IDLE;
      step  <= '0;
      dim   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      dim   <= dim_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    dim_next   = dim;
    case (state)
      tra_pkg::ST_IDLE: begin
        if (accept && req_type == tra_pkg::REQ_SHIFT && status.axis_ok) begin
          state_next = tra_pkg::ST_DIV;
          step_next  = '0;
        end else if (accept && req_type == tra_pkg::REQ_DATA) begin
          state_next = tra_pkg::ST_MUL;
          dim_next   = tra_pkg::DIM_IDX_BITS'(status.eff_rank - tra_pkg::RANK_BITS'(1));
        end
      end
      tra_pkg::ST_DIV: begin
        if (step == tra_pkg::STEP_BITS'(tra_pkg::ABS_BITS - 1)) begin
          state_next = tra_pkg::ST_FIX;
        end else begin
          step_next = step + tra_pkg::STEP_BITS'(1);
        end
      end
      tra_pkg::ST_FIX: begin
        state_next = tra_pkg::ST_IDLE;
      end
      tra_pkg::ST_MUL: begin
        if (dim == '0) begin
          state_next = tra_pkg::ST_DONE;
        end else begin
          state_next = tra_pkg::ST_STRIDE;
        end
      end
      tra_pkg::ST_STRIDE: begin
        state_next = tra_pkg::ST_MUL;
        dim_next   = dim - tra_pkg::DIM_IDX_BITS'(1);
      end
      tra_pkg::ST_DONE: begin
        if (status.out_free) state_next = tra_pkg::ST_IDLE;
      end
      default: begin
        state_next = tra_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.dim  = dim;
    s_tready = 1'b0;
    case (state)
      tra_pkg::ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.clear      = accept && req_type == tra_pkg::REQ_START;
        cmd.shift_load = accept && req_type == tra_pkg::REQ_SHIFT && status.axis_ok;
        cmd.elem_load  = accept && req_type == tra_pkg::REQ_DATA;
      end
      tra_pkg::ST_DIV:    cmd.div_step    = 1'b1;
      tra_pkg::ST_FIX:    cmd.shift_store = 1'b1;
      tra_pkg::ST_MUL:    cmd.mul_acc     = 1'b1;
      tra_pkg::ST_STRIDE: cmd.mul_stride  = 1'b1;
      tra_pkg::ST_DONE:   cmd.out_load    = status.out_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

[hdl/tra_dp.sv]
// tra_dp: config registers, per-axis shift and coordinate state, serial modulo unit,
// shared stride multiplier and output register; depends on tra_pkg, driven by tra_ctrl
module tra_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tra_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [tra_pkg::S_TDATA_BITS-1:0]   s_tdata,
  input  tra_pkg::cmd_t                      cmd,
  output tra_pkg::status_t                   status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tra_pkg::M_TDATA_BITS-1:0]   m_tdata,
  output logic                               m_tlast
);

  logic [tra_pkg::RANK_BITS-1:0]  rank;
  logic [tra_pkg::DIM_BITS-1:0]   size_reg   [tra_pkg::MAX_RANK];
  logic [tra_pkg::DIM_BITS-1:0]   axis_shift [tra_pkg::MAX_RANK];
  logic [tra_pkg::DIM_BITS-1:0]   coordinate [tra_pkg::MAX_RANK];
  logic [tra_pkg::DIM_BITS-1:0]   coord_next [tra_pkg::MAX_RANK];
  logic [tra_pkg::DIM_BITS-1:0]   sz         [tra_pkg::MAX_RANK];

  logic [tra_pkg::RANK_BITS-1:0]  r_eff;

  // input fields
  logic signed [tra_pkg::AXIS_BITS-1:0]  axis_in;
  logic [tra_pkg::SHIFT_BITS-1:0]        shift_in;
  logic [tra_pkg::VALUE_BITS-1:0]        value_in;

  // axis mapping
  logic signed [tra_pkg::AXIS_BITS:0]    axis_adj;
  logic [tra_pkg::DIM_IDX_BITS-1:0]      axis_idx;
  logic                                  axis_ok;

  // modulo unit
  logic signed [tra_pkg::SUM_BITS-1:0]   sum_w, abs_full;
  logic [tra_pkg::ABS_BITS-1:0]          dividend;
  logic [tra_pkg::DIM_BITS-1:0]          rem, div_size;
  logic [tra_pkg::DIM_BITS:0]            rem_sh;
  logic                                  neg;
  logic [tra_pkg::DIM_IDX_BITS-1:0]      axis_sel;

  // offset accumulation
  logic [tra_pkg::ADDR_BITS-1:0]         offset, stride;
  logic [tra_pkg::VALUE_BITS-1:0]        value_reg;
  logic [tra_pkg::DIM_BITS:0]            pos_sum, pos, mult_b;
  logic [tra_pkg::PROD_BITS-1:0]         prod;
  logic                                  last;

  assign axis_in  = s_tdata[tra_pkg::AXIS_BITS-1:0];
  assign shift_in = s_tdata[tra_pkg::AXIS_BITS +: tra_pkg::SHIFT_BITS];
  assign value_in = s_tdata[tra_pkg::AXIS_BITS + tra_pkg::SHIFT_BITS +: tra_pkg::VALUE_BITS];

  assign r_eff = tra_pkg::eff_rank(rank);

  always_comb begin
    for (int d = 0; d < tra_pkg::MAX_RANK; d++) begin
      sz[d] = tra_pkg::eff_size(size_reg[d]);
    end
  end

  always_comb begin
    axis_adj = {axis_in[tra_pkg::AXIS_BITS-1], axis_in};
    if (axis_in[tra_pkg::AXIS_BITS-1]) begin
      axis_adj = axis_adj + $signed({1'b0, r_eff});
    end
    axis_ok  = !axis_adj[tra_pkg::AXIS_BITS] &&
               (axis_adj[tra_pkg::AXIS_BITS-1:0] < r_eff);
    axis_idx = axis_adj[tra_pkg::DIM_IDX_BITS-1:0];
  end

  assign sum_w = $signed({{(tra_pkg::SUM_BITS - tra_pkg::DIM_BITS){1'b0}},
                          axis_shift[axis_idx]}) +
                 $signed({{(tra_pkg::SUM_BITS - tra_pkg::SHIFT_BITS){shift_in[tra_pkg::SHIFT_BITS-1]}},
                          shift_in});
  assign abs_full = sum_w[tra_pkg::SUM_BITS-1] ? -sum_w : sum_w;
  assign rem_sh   = {rem, dividend[tra_pkg::ABS_BITS-1]};

  // wrapped position and shared multiplier
  assign pos_sum = {1'b0, coordinate[cmd.dim]} + {1'b0, axis_shift[cmd.dim]};
  assign pos     = (pos_sum >= {1'b0, sz[cmd.dim]}) ? pos_sum - {1'b0, sz[cmd.dim]} : pos_sum;
  assign mult_b  = cmd.mul_stride ? {1'b0, sz[cmd.dim]} : pos;
  assign prod    = tra_pkg::PROD_BITS'(stride) * tra_pkg::PROD_BITS'(mult_b);

  // coordinate counter and last flag
  always_comb begin
    logic carry;
    logic [tra_pkg::DIM_BITS:0] inc;
    carry = 1'b1;
    last  = 1'b1;
    for (int d = tra_pkg::MAX_RANK - 1; d >= 0; d--) begin
      inc = {1'b0, coordinate[d]} + (tra_pkg::DIM_BITS + 1)'(1);
      coord_next[d] = coordinate[d];
      if (d < int'(r_eff)) begin
        if (inc < {1'b0, sz[d]}) last = 1'b0;
        if (carry) begin
          if (inc >= {1'b0, sz[d]}) begin
            coord_next[d] = '0;
          end else begin
            coord_next[d] = inc[tra_pkg::DIM_BITS-1:0];
            carry = 1'b0;
          end
        end
      end
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= tra_pkg::RANK_BITS'(1);
      for (int d = 0; d < tra_pkg::MAX_RANK; d++) size_reg[d] <= tra_pkg::DIM_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tra_pkg::REG_RANK:  rank        <= cfg_data[tra_pkg::RANK_BITS-1:0];
        tra_pkg::REG_SIZE0: size_reg[0] <= cfg_data;
        tra_pkg::REG_SIZE1: size_reg[1] <= cfg_data;
        tra_pkg::REG_SIZE2: size_reg[2] <= cfg_data;
        tra_pkg::REG_SIZE3: size_reg[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // per-axis state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int d = 0; d < tra_pkg::MAX_RANK; d++) begin
        axis_shift[d] <= '0;
        coordinate[d] <= '0;
      end
    end else begin
      if (cmd.shift_store) begin
        axis_shift[axis_sel] <= (neg && rem != '0) ? div_size - rem : rem;
      end
      if (cmd.out_load) begin
        for (int d = 0; d < tra_pkg::MAX_RANK; d++) coordinate[d] <= coord_next[d];
      end
    end
  end

  // serial modulo, one dividend bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.shift_load) begin
      dividend <= abs_full[tra_pkg::ABS_BITS-1:0];
      neg      <= sum_w[tra_pkg::SUM_BITS-1];
      rem      <= '0;
      div_size <= sz[axis_idx];
      axis_sel <= axis_idx;
    end else if (cmd.div_step) begin
      dividend <= {dividend[tra_pkg::ABS_BITS-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_size}) begin
        rem <= tra_pkg::DIM_BITS'(rem_sh - {1'b0, div_size});
      end else begin
        rem <= rem_sh[tra_pkg::DIM_BITS-1:0];
      end
    end
  end

  // offset accumulation
  always_ff @(posedge clk) begin
    if (cmd.elem_load) begin
      offset    <= '0;
      stride    <= tra_pkg::ADDR_BITS'(1);
      value_reg <= value_in;
    end else if (cmd.mul_acc) begin
      offset <= offset + prod[tra_pkg::ADDR_BITS-1:0];
    end else if (cmd.mul_stride) begin
      stride <= prod[tra_pkg::ADDR_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {value_reg, offset};
      m_tlast <= last;
    end
  end

  assign status.axis_ok  = axis_ok;
  assign status.out_free = !m_tvalid || m_tready;
  assign status.eff_rank = r_eff;

endmodule

[hdl/tensor_roll_address_generator_unit.sv]
// tensor_roll_address_generator_unit: top level of the tensor roll address generator
// depends on tra_pkg, tra_ctrl and tra_dp
//
// Circular shift (roll) of a row-major tensor of up to four dimensions. A start beat
// (tuser 0) clears shifts and coordinates as it is accepted. For an axis/shift beat
// (tuser 1) the new shift total is reduced modulo the axis size by a serial
// restoring remainder unit, one dividend bit per cycle over 33 bits, and then stored;
// an out-of-range axis is accepted and dropped. For a data beat (tuser 2) a single
// 32x17 multiplier alternates between adding wrapped coordinate times stride and
// stepping the stride, innermost axis first, before the result is handed off. The
// output register lets the next beat be accepted while a result waits. Sizes of 0
// act as 1, rank is clamped to 1..4, and offsets wrap modulo 2^32.
module tensor_roll_address_generator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tra_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tra_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tra_pkg::S_TDATA_BITS-1:0]   s_tdata,   // axis, shift_amount, elem_value, zero pad
  input  logic [tra_pkg::REQ_BITS-1:0]       s_tuser,   // req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tra_pkg::M_TDATA_BITS-1:0]   m_tdata,   // dest_offset, out_value
  output logic                               m_tlast
);

  tra_pkg::cmd_t    cmd;
  tra_pkg::status_t status;

  tra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.shift_load, cmd.div_step, cmd.shift_store,
              cmd.elem_load, cmd.mul_acc, cmd.mul_stride, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending beat");

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not presented");

  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == tra_pkg::REQ_DATA) |=> !s_tready)
    else $error("data beat did not start address computation");

endmodule
